### hdl/pixel_color_format_converter_macros.svh
// Assertion helpers used by the converter RTL (pcfc_pack).
`ifndef PIXEL_COLOR_FORMAT_CONVERTER_MACROS_SVH
`define PIXEL_COLOR_FORMAT_CONVERTER_MACROS_SVH

// Same-cycle implication, checked on clk and muted while in reset.
`define PCFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and muted while in reset.
`define PCFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/pcfc_pkg.sv
package pcfc_pkg;

	typedef enum logic [1:0] {
		FMT_RGBA8888 = 2'd0,
		FMT_RGBA16X4 = 2'd1,
		FMT_RGB555A1 = 2'd2,
		FMT_RGB10A2  = 2'd3
	} fmt_t;

	typedef struct packed {
		fmt_t src_fmt;
		logic src_ainv;
		fmt_t dst_fmt;
		logic dst_ainv;
	} cfg_t;

	// Four channels, each normalized to 16 bits.
	typedef struct packed {
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] g;
		logic [15:0] r;
	} chan_t;

	typedef struct packed {
		chan_t ch;
		fmt_t  dst;
	} chan_word_t;

	function automatic logic [15:0] widen5(input logic [4:0] x);
		return {x, x, x, x[4]};
	endfunction

	function automatic logic [15:0] widen8(input logic [7:0] x);
		return {x, x};
	endfunction

	function automatic logic [15:0] widen10(input logic [9:0] x);
		return {x, x[9:4]};
	endfunction

	// Split a packed pixel into 16-bit channels, repeating top bits downward.
	function automatic chan_t unpack_pixel(input logic [63:0] p, input fmt_t f);
		chan_t c;
		case (f)
			FMT_RGBA8888: begin
				c.r = widen8(p[7:0]);
				c.g = widen8(p[15:8]);
				c.b = widen8(p[23:16]);
				c.a = widen8(p[31:24]);
			end
			FMT_RGBA16X4: begin
				c.r = p[15:0];
				c.g = p[31:16];
				c.b = p[47:32];
				c.a = p[63:48];
			end
			FMT_RGB555A1: begin
				c.r = widen5(p[4:0]);
				c.g = widen5(p[9:5]);
				c.b = widen5(p[14:10]);
				c.a = {16{p[15]}};
			end
			FMT_RGB10A2: begin
				c.r = widen10(p[9:0]);
				c.g = widen10(p[19:10]);
				c.b = widen10(p[29:20]);
				c.a = {8{p[31:30]}};
			end
			default: begin
				c = '0;
			end
		endcase
		return c;
	endfunction

	// Keep the top bits of each channel and place them in the target layout.
	function automatic logic [63:0] pack_pixel(input chan_t c, input fmt_t f);
		logic [63:0] p;
		case (f)
			FMT_RGBA8888: p = {32'd0, c.a[15:8], c.b[15:8], c.g[15:8], c.r[15:8]};
			FMT_RGBA16X4: p = {c.a, c.b, c.g, c.r};
			FMT_RGB555A1: p = {48'd0, c.a[15], c.b[15:11], c.g[15:11], c.r[15:11]};
			FMT_RGB10A2:  p = {32'd0, c.a[15:14], c.b[15:6], c.g[15:6], c.r[15:6]};
			default:      p = '0;
		endcase
		return p;
	endfunction

endpackage

### hdl/pcfc_if.sv
interface pcfc_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

interface pcfc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] pixel_out;

	modport source (output valid, output pixel_out, input ready);
	modport sink (input valid, input pixel_out, output ready);
endinterface

### hdl/pcfc_cfg.sv
module pcfc_cfg
	import pcfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	localparam logic [1:0] REG_SOURCE_FORMAT         = 2'd0;
	localparam logic [1:0] REG_SOURCE_ALPHA_INVERTED = 2'd1;
	localparam logic [1:0] REG_TARGET_FORMAT         = 2'd2;
	localparam logic [1:0] REG_TARGET_ALPHA_INVERTED = 2'd3;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_fmt  <= FMT_RGBA8888;
			cfg_q.src_ainv <= 1'b0;
			cfg_q.dst_fmt  <= FMT_RGBA8888;
			cfg_q.dst_ainv <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SOURCE_FORMAT:         cfg_q.src_fmt  <= fmt_t'(pwdata[1:0]);
				REG_SOURCE_ALPHA_INVERTED: cfg_q.src_ainv <= pwdata[0];
				REG_TARGET_FORMAT:         cfg_q.dst_fmt  <= fmt_t'(pwdata[1:0]);
				REG_TARGET_ALPHA_INVERTED: cfg_q.dst_ainv <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SOURCE_FORMAT:         prdata = {30'd0, cfg_q.src_fmt};
			REG_SOURCE_ALPHA_INVERTED: prdata = {31'd0, cfg_q.src_ainv};
			REG_TARGET_FORMAT:         prdata = {30'd0, cfg_q.dst_fmt};
			REG_TARGET_ALPHA_INVERTED: prdata = {31'd0, cfg_q.dst_ainv};
			default:                   prdata = '0;
		endcase
	end

endmodule

### hdl/pcfc_unpack.sv
module pcfc_unpack
	import pcfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	pcfc_in_if.sink    in_ch,
	output logic       down_valid,
	input  logic       down_ready,
	output chan_word_t down_word
);

	logic        valid_s1;
	logic [63:0] pix_s1;
	fmt_t        src_s1;
	fmt_t        dst_s1;
	logic        flip_s1;
	logic        ready_s1;

	logic        valid_s2;
	chan_word_t  word_s2;
	logic        ready_s2;

	chan_t       ch_comb;

	assign ready_s2    = !valid_s2 || down_ready;
	assign ready_s1    = !valid_s1 || ready_s2;
	assign in_ch.ready = ready_s1;

	// Capture the word with the layout it was sent under.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_ch.valid) begin
			pix_s1  <= in_ch.pixel_in;
			src_s1  <= cfg.src_fmt;
			dst_s1  <= cfg.dst_fmt;
			flip_s1 <= cfg.src_ainv ^ cfg.dst_ainv;
		end
	end

	// Flip alpha before narrowing: same bits as flipping the target field.
	always_comb begin
		ch_comb   = unpack_pixel(pix_s1, src_s1);
		ch_comb.a = ch_comb.a ^ {16{flip_s1}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			word_s2.ch  <= ch_comb;
			word_s2.dst <= dst_s1;
		end
	end

	assign down_valid = valid_s2;
	assign down_word  = word_s2;

endmodule

### hdl/pcfc_pack.sv
`include "pixel_color_format_converter_macros.svh"

module pcfc_pack
	import pcfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	output logic       up_ready,
	input  chan_word_t up_word,
	pcfc_out_if.source out_ch
);

	logic        valid_s3;
	logic [63:0] pix_s3;
	fmt_t        dst_s3;
	logic        ready_s3;

	assign ready_s3 = !valid_s3 || out_ch.ready;
	assign up_ready = ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && up_valid) begin
			pix_s3 <= pack_pixel(up_word.ch, up_word.dst);
			dst_s3 <= up_word.dst;
		end
	end

	assign out_ch.valid     = valid_s3;
	assign out_ch.pixel_out = pix_s3;

	`PCFC_ASSERT_NOW(a_narrow16_zero_top, valid_s3 && dst_s3 == FMT_RGB555A1, pix_s3[63:16] == '0, "16-bit word has bits above its width")
	`PCFC_ASSERT_NOW(a_narrow32_zero_top, valid_s3 && (dst_s3 == FMT_RGBA8888 || dst_s3 == FMT_RGB10A2), pix_s3[63:32] == '0, "32-bit word has bits above its width")
	`PCFC_ASSERT_NEXT(a_stall_keeps_word, valid_s3 && !out_ch.ready, valid_s3 && $stable(pix_s3), "stalled output word lost or changed")

endmodule

### hdl/pixel_color_format_converter.sv
// Packed pixel format converter.
// source_ch takes one packed pixel word per handshake (valid and ready both
// high at a rising clk edge); target_ch returns the converted word with the
// same handshake. Layouts and alpha-invert flags come from four registers on
// the APB-style port (byte address 4*i, pready tied high, reads return the
// register). Write them only while no word is in flight.
// Path: a word passes three registered stages in order on its way to
// target_ch: input capture, channel expansion to 16 bits, repack.
// Throughput: one word per cycle while target_ch is not stalling; every
// stage has its own valid bit, so bubbles close up under backpressure.
// Reset (arst_n low) clears the valid bits and returns the config registers
// to zero (rgba8888 in and out, no alpha inversion). When the receiver
// stalls, the output word holds, stages fill behind it, and source_ch drops
// ready once all three stages hold words.
module pixel_color_format_converter
	import pcfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pcfc_in_if.sink     source_ch,
	pcfc_out_if.source  target_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t       cfg;
	logic       mid_valid;
	logic       mid_ready;
	chan_word_t mid_word;

	// Register file: hold the layout selection and alpha flags.
	pcfc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Front stages: capture the word, expand each channel to 16 bits.
	pcfc_unpack u_unpack (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_ch      (source_ch),
		.down_valid (mid_valid),
		.down_ready (mid_ready),
		.down_word  (mid_word)
	);

	// Last stage: narrow and place channels in the target layout.
	pcfc_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (mid_valid),
		.up_ready (mid_ready),
		.up_word  (mid_word),
		.out_ch   (target_ch)
	);

endmodule
